// ===== src/atce_pkg.sv =====
// atce_pkg: shared types, character codes and the sgr palette for the terminal cursor engine
// no dependencies; used by every module of the block
`default_nettype none

package atce_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 128;

    localparam int COL_W  = 8;   // cursor column width
    localparam int ROW_W  = 7;   // cursor row width
    localparam int CFGC_W = 9;   // columns register width
    localparam int CFGR_W = 8;   // rows register width
    localparam int CODE_W = 16;

    // configuration register indexes
    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    // character codes
    localparam logic [CODE_W-1:0] CODE_BEL    = 16'h0007;
    localparam logic [CODE_W-1:0] CODE_BS     = 16'h0008;
    localparam logic [CODE_W-1:0] CODE_HT     = 16'h0009;
    localparam logic [CODE_W-1:0] CODE_LF     = 16'h000A;
    localparam logic [CODE_W-1:0] CODE_FF     = 16'h000C;
    localparam logic [CODE_W-1:0] CODE_CR     = 16'h000D;
    localparam logic [CODE_W-1:0] CODE_ESC    = 16'h001B;
    localparam logic [CODE_W-1:0] CODE_LBRACK = 16'h005B;
    localparam logic [CODE_W-1:0] CODE_SEMI   = 16'h003B;
    localparam logic [CODE_W-1:0] CODE_ZERO   = 16'h0030;
    localparam logic [CODE_W-1:0] CODE_NINE   = 16'h0039;
    localparam logic [CODE_W-1:0] CODE_UP     = 16'h0041;  // A
    localparam logic [CODE_W-1:0] CODE_DOWN   = 16'h0042;  // B
    localparam logic [CODE_W-1:0] CODE_FWD    = 16'h0043;  // C
    localparam logic [CODE_W-1:0] CODE_BACK   = 16'h0044;  // D
    localparam logic [CODE_W-1:0] CODE_NEXTLN = 16'h0045;  // E
    localparam logic [CODE_W-1:0] CODE_PREVLN = 16'h0046;  // F
    localparam logic [CODE_W-1:0] CODE_HABS   = 16'h0047;  // G
    localparam logic [CODE_W-1:0] CODE_POS    = 16'h0048;  // H
    localparam logic [CODE_W-1:0] CODE_SGR    = 16'h006D;  // m

    localparam logic [3:0] FG_DEFAULT = 4'd15;
    localparam logic [3:0] BG_DEFAULT = 4'd0;

    typedef enum logic [2:0] {
        MODE_TEXT = 3'b001,
        MODE_ESC  = 3'b010,
        MODE_CSI  = 3'b100
    } mode_t;

    // decoded code point from the utf-8 stage
    typedef struct packed {
        logic              have;
        logic [CODE_W-1:0] code;
    } dec_t;

    typedef struct packed {
        logic              put_valid;
        logic [CODE_W-1:0] put_code;
        logic [COL_W-1:0]  put_column;
        logic [ROW_W-1:0]  put_row;
        logic [3:0]        fg_color;
        logic [3:0]        bg_color;
        logic              scroll_up;
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
    } res_t;

    function automatic logic [3:0] sgr_palette(input logic [2:0] idx);
        logic [3:0] c;
        case (idx)
            3'd0:    c = 4'd8;
            3'd1:    c = 4'd12;
            3'd2:    c = 4'd10;
            3'd3:    c = 4'd14;
            3'd4:    c = 4'd9;
            3'd5:    c = 4'd13;
            3'd6:    c = 4'd11;
            default: c = 4'd15;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/atce_utf8_dec.sv =====
// atce_utf8_dec: utf-8 byte decoder holding the pending sequence state
// depends on atce_pkg
`default_nettype none

module atce_utf8_dec (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire logic [7:0]   byte_val,
    output atce_pkg::dec_t    dec
);

    logic [1:0]  rem_reg, rem_next;
    logic [15:0] acc_reg, acc_next;

    always_comb
    begin
        rem_next = rem_reg;
        acc_next = acc_reg;
        dec.have = 1'b0;
        dec.code = '0;
        if (rem_reg != 2'd0)
        begin
            if (byte_val[7:6] == 2'b10)
            begin
                acc_next = {acc_reg[9:0], byte_val[5:0]};
                rem_next = rem_reg - 2'd1;
                if (rem_reg == 2'd1)
                begin
                    dec.have = 1'b1;
                    dec.code = {acc_reg[9:0], byte_val[5:0]};
                end
            end
            else
            begin
                // broken sequence: drop the byte, emit code 0
                rem_next = 2'd0;
                dec.have = 1'b1;
            end
        end
        else if (byte_val[7:3] == 5'b11110)
        begin
            rem_next = 2'd3;
            acc_next = {13'd0, byte_val[2:0]};
        end
        else if (byte_val[7:4] == 4'b1110)
        begin
            rem_next = 2'd2;
            acc_next = {12'd0, byte_val[3:0]};
        end
        else if (byte_val[7:5] == 3'b110)
        begin
            rem_next = 2'd1;
            acc_next = {11'd0, byte_val[4:0]};
        end
        else
        begin
            dec.have = 1'b1;
            dec.code = {9'd0, byte_val[6:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 2'd0;
            acc_reg <= '0;
        end
        else if (en)
        begin
            rem_reg <= rem_next;
            acc_reg <= acc_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/atce_cursor.sv =====
// atce_cursor: escape sequence parser, cursor, colors and text handling
// depends on atce_pkg; takes decoded code points from atce_utf8_dec
`default_nettype none

module atce_cursor (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire atce_pkg::dec_t               dec,
    input  wire logic [atce_pkg::CFGC_W-1:0]  ec,
    input  wire logic [atce_pkg::CFGR_W-1:0]  er,
    input  wire logic [atce_pkg::COL_W-1:0]   maxc,
    input  wire logic [atce_pkg::ROW_W-1:0]   maxr,
    output atce_pkg::res_t                    res
);

    atce_pkg::mode_t mode_reg, mode_next;
    logic        pidx_reg, pidx_next;
    logic        pextra_reg, pextra_next;
    logic [15:0] pval_reg [2];
    logic [15:0] pval_next [2];
    logic [1:0]  ppres_reg, ppres_next;
    logic [atce_pkg::COL_W-1:0] col_reg, col_next, col0;
    logic [atce_pkg::ROW_W-1:0] row_reg, row_next, row0;
    logic [3:0]  fg_reg, fg_next, bg_reg, bg_next;

    logic [8:0]  c9;
    logic [7:0]  r8;
    logic [15:0] p0, p1, p0_pos, p1_pos, dig;
    logic [19:0] acc20;
    logic [16:0] row_sum, col_sum;
    logic        put_v, scroll;

    always_comb
    begin
        col0 = (col_reg > maxc) ? maxc : col_reg;
        row0 = (row_reg > maxr) ? maxr : row_reg;

        p0 = ppres_reg[0] ? pval_reg[0] : 16'd1;
        p1 = ppres_reg[1] ? pval_reg[1] : 16'd1;
        p0_pos = (p0 == 16'd0) ? 16'd0 : p0 - 16'd1;
        p1_pos = (p1 == 16'd0) ? 16'd0 : p1 - 16'd1;
        row_sum = {10'd0, row0} + {1'b0, p0};
        col_sum = {9'd0, col0} + {1'b0, p0};

        dig = dec.code - atce_pkg::CODE_ZERO;
        acc20 = ppres_reg[pidx_reg]
              ? ({4'd0, pval_reg[pidx_reg]} << 3) + ({4'd0, pval_reg[pidx_reg]} << 1)
                + {16'd0, dig[3:0]}
              : {16'd0, dig[3:0]};

        mode_next    = mode_reg;
        pidx_next    = pidx_reg;
        pextra_next  = pextra_reg;
        pval_next[0] = pval_reg[0];
        pval_next[1] = pval_reg[1];
        ppres_next   = ppres_reg;
        fg_next      = fg_reg;
        bg_next      = bg_reg;
        c9           = {1'b0, col0};
        r8           = {1'b0, row0};
        put_v        = 1'b0;
        scroll       = 1'b0;

        if (dec.have)
        begin
            unique case (mode_reg)
                atce_pkg::MODE_TEXT:
                begin
                    case (dec.code)
                        atce_pkg::CODE_BEL: ;
                        atce_pkg::CODE_BS:
                            if (col0 != '0)
                                c9 = {1'b0, col0} - 9'd1;
                        atce_pkg::CODE_HT:  c9 = ({1'b0, col0} + 9'd8) & ~9'd7;
                        atce_pkg::CODE_LF:
                        begin
                            c9 = '0;
                            r8 = {1'b0, row0} + 8'd1;
                        end
                        atce_pkg::CODE_FF:  r8 = {1'b0, row0} + 8'd1;
                        atce_pkg::CODE_CR:  c9 = '0;
                        atce_pkg::CODE_ESC:
                        begin
                            mode_next    = atce_pkg::MODE_ESC;
                            pidx_next    = 1'b0;
                            pextra_next  = 1'b0;
                            pval_next[0] = '0;
                            pval_next[1] = '0;
                            ppres_next   = '0;
                        end
                        default:
                        begin
                            put_v = 1'b1;
                            c9 = {1'b0, col0} + 9'd1;
                        end
                    endcase
                    // line wrap then scroll
                    if (c9 >= ec)
                    begin
                        c9 = '0;
                        r8 = r8 + 8'd1;
                    end
                    if (r8 >= er)
                    begin
                        scroll = 1'b1;
                        c9 = '0;
                        r8 = er - 8'd1;
                    end
                end
                atce_pkg::MODE_ESC:
                begin
                    if (dec.code == atce_pkg::CODE_LBRACK)
                        mode_next = atce_pkg::MODE_CSI;
                    else
                    begin
                        mode_next    = atce_pkg::MODE_TEXT;
                        pidx_next    = 1'b0;
                        pextra_next  = 1'b0;
                        pval_next[0] = '0;
                        pval_next[1] = '0;
                        ppres_next   = '0;
                    end
                end
                atce_pkg::MODE_CSI:
                begin
                    if (dec.code >= atce_pkg::CODE_ZERO && dec.code <= atce_pkg::CODE_NINE)
                    begin
                        if (!pextra_reg)
                        begin
                            pval_next[pidx_reg]  = (acc20 > 20'h0FFFF) ? 16'hFFFF : acc20[15:0];
                            ppres_next[pidx_reg] = 1'b1;
                        end
                    end
                    else if (dec.code == atce_pkg::CODE_SEMI)
                    begin
                        if (!pidx_reg)
                            pidx_next = 1'b1;
                        else
                            pextra_next = 1'b1;
                    end
                    else
                    begin
                        case (dec.code) inside
                            atce_pkg::CODE_UP, atce_pkg::CODE_PREVLN:
                            begin
                                r8 = (p0 >= {9'd0, row0}) ? 8'd0
                                   : {1'b0, row0 - p0[atce_pkg::ROW_W-1:0]};
                                if (dec.code == atce_pkg::CODE_PREVLN)
                                    c9 = '0;
                            end
                            atce_pkg::CODE_DOWN, atce_pkg::CODE_NEXTLN:
                            begin
                                r8 = (row_sum > {10'd0, maxr}) ? {1'b0, maxr}
                                   : {1'b0, row_sum[atce_pkg::ROW_W-1:0]};
                                if (dec.code == atce_pkg::CODE_NEXTLN)
                                    c9 = '0;
                            end
                            atce_pkg::CODE_FWD:
                                c9 = (col_sum > {9'd0, maxc}) ? {1'b0, maxc}
                                   : {1'b0, col_sum[atce_pkg::COL_W-1:0]};
                            atce_pkg::CODE_BACK:
                                c9 = (p0 >= {8'd0, col0}) ? 9'd0
                                   : {1'b0, col0 - p0[atce_pkg::COL_W-1:0]};
                            atce_pkg::CODE_HABS:
                                c9 = (p0_pos > {8'd0, maxc}) ? {1'b0, maxc}
                                   : {1'b0, p0_pos[atce_pkg::COL_W-1:0]};
                            atce_pkg::CODE_POS:
                            begin
                                r8 = (p0_pos > {9'd0, maxr}) ? {1'b0, maxr}
                                   : {1'b0, p0_pos[atce_pkg::ROW_W-1:0]};
                                c9 = (p1_pos > {8'd0, maxc}) ? {1'b0, maxc}
                                   : {1'b0, p1_pos[atce_pkg::COL_W-1:0]};
                            end
                            atce_pkg::CODE_SGR:
                            begin
                                if (!ppres_reg[0] || pval_reg[0] == 16'd0)
                                begin
                                    fg_next = atce_pkg::FG_DEFAULT;
                                    bg_next = atce_pkg::BG_DEFAULT;
                                end
                                else if (pval_reg[0] >= 16'd30 && pval_reg[0] <= 16'd37)
                                    // 30 is 6 mod 8
                                    fg_next = atce_pkg::sgr_palette(pval_reg[0][2:0] - 3'd6);
                                else if (pval_reg[0] >= 16'd40 && pval_reg[0] <= 16'd47)
                                    bg_next = atce_pkg::sgr_palette(pval_reg[0][2:0]);
                            end
                            default: ;
                        endcase
                        mode_next    = atce_pkg::MODE_TEXT;
                        pidx_next    = 1'b0;
                        pextra_next  = 1'b0;
                        pval_next[0] = '0;
                        pval_next[1] = '0;
                        ppres_next   = '0;
                    end
                end
                default: mode_next = atce_pkg::MODE_TEXT;
            endcase
        end

        col_next = c9[atce_pkg::COL_W-1:0];
        row_next = r8[atce_pkg::ROW_W-1:0];

        res.put_valid     = put_v;
        res.put_code      = put_v ? dec.code : '0;
        res.put_column    = put_v ? col0 : '0;
        res.put_row       = put_v ? row0 : '0;
        res.fg_color      = fg_next;
        res.bg_color      = bg_next;
        res.scroll_up     = scroll;
        res.cursor_column = col_next;
        res.cursor_row    = row_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= atce_pkg::MODE_TEXT;
            pidx_reg    <= 1'b0;
            pextra_reg  <= 1'b0;
            pval_reg[0] <= '0;
            pval_reg[1] <= '0;
            ppres_reg   <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            fg_reg      <= atce_pkg::FG_DEFAULT;
            bg_reg      <= atce_pkg::BG_DEFAULT;
        end
        else if (en)
        begin
            mode_reg    <= mode_next;
            pidx_reg    <= pidx_next;
            pextra_reg  <= pextra_next;
            pval_reg[0] <= pval_next[0];
            pval_reg[1] <= pval_next[1];
            ppres_reg   <= ppres_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            fg_reg      <= fg_next;
            bg_reg      <= bg_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/ansi_terminal_cursor_engine_core.sv =====
// ansi_terminal_cursor_engine_core: top level with input stage, config registers, result register
// depends on atce_pkg, atce_utf8_dec and atce_cursor
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    byte_in
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
// out       output     out_valid / out_ready  put_*, fg/bg_color, scroll_up, cursor_*
//
// one byte per cycle sustained while the output is not stalled; a byte is accepted into the
// input register, processed in one pass through the utf-8 decoder and cursor logic when it
// advances, and lands in the result register, where its result is presented until taken.
// reset returns 80 columns, 25 rows, cursor home, white on black.
// when the result register is stalled the input register holds one more byte, then
// in_ready drops; the config port is always ready.
`default_nettype none

module ansi_terminal_cursor_engine_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [7:0]                  byte_in,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic                        cfg_index,
    input  wire logic [atce_pkg::CFGC_W-1:0] cfg_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             put_valid,
    output logic [15:0]                      put_code,
    output logic [atce_pkg::COL_W-1:0]       put_column,
    output logic [atce_pkg::ROW_W-1:0]       put_row,
    output logic [3:0]                       fg_color,
    output logic [3:0]                       bg_color,
    output logic                             scroll_up,
    output logic [atce_pkg::COL_W-1:0]       cursor_column,
    output logic [atce_pkg::ROW_W-1:0]       cursor_row
);

    logic [atce_pkg::CFGC_W-1:0] columns_reg;
    logic [atce_pkg::CFGR_W-1:0] rows_reg;
    logic [atce_pkg::CFGC_W-1:0] ec;
    logic [atce_pkg::CFGR_W-1:0] er;
    logic [atce_pkg::COL_W-1:0]  maxc;
    logic [atce_pkg::ROW_W-1:0]  maxr;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        out_valid_reg;
    logic        advance;

    atce_pkg::dec_t dec;
    atce_pkg::res_t res, res_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= 9'd80;
            rows_reg    <= 8'd25;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                atce_pkg::CFG_COLUMNS: columns_reg <= cfg_data;
                atce_pkg::CFG_ROWS:    rows_reg    <= cfg_data[atce_pkg::CFGR_W-1:0];
                default: ;
            endcase
        end
    end

    // effective screen size, clamped to 1..max
    always_comb
    begin
        if (columns_reg == '0)
            ec = 9'd1;
        else if (columns_reg > atce_pkg::CFGC_W'(atce_pkg::MAX_COLUMNS))
            ec = atce_pkg::CFGC_W'(atce_pkg::MAX_COLUMNS);
        else
            ec = columns_reg;
        if (rows_reg == '0)
            er = 8'd1;
        else if (rows_reg > atce_pkg::CFGR_W'(atce_pkg::MAX_ROWS))
            er = atce_pkg::CFGR_W'(atce_pkg::MAX_ROWS);
        else
            er = rows_reg;
    end

    assign maxc = atce_pkg::COL_W'(ec - 9'd1);
    assign maxr = atce_pkg::ROW_W'(er - 8'd1);

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_byte_reg <= byte_in;
    end

    atce_utf8_dec u_dec (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .byte_val (s1_byte_reg),
        .dec      (dec)
    );

    atce_cursor u_cursor (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .dec   (dec),
        .ec    (ec),
        .er    (er),
        .maxc  (maxc),
        .maxr  (maxr),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign put_valid     = res_reg.put_valid;
    assign put_code      = res_reg.put_code;
    assign put_column    = res_reg.put_column;
    assign put_row       = res_reg.put_row;
    assign fg_color      = res_reg.fg_color;
    assign bg_color      = res_reg.bg_color;
    assign scroll_up     = res_reg.scroll_up;
    assign cursor_column = res_reg.cursor_column;
    assign cursor_row    = res_reg.cursor_row;

    // an empty result register never holds back the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    // a scroll always leaves the cursor at the start of the last row
    a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && scroll_up) |-> (cursor_column == '0 && cursor_row == maxr))
        else $error("scroll with cursor off the last row start");

    // written cells lie on screen, and an empty write carries zeros
    a_put_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && put_valid) |-> (put_column <= maxc && put_row <= maxr))
        else $error("cell write outside the screen");

    a_put_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !put_valid) |-> (put_code == '0 && put_column == '0))
        else $error("payload present without a cell write");

endmodule

`default_nettype wire
